@@ rtl/core/stbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and codes for the timestamp table bracket search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam int ROW_CNT_W = 11;
  localparam int IDX_W     = 10;
  localparam int TIME_W    = 64;

  // Input item: table load or query
  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         entry_index;
    logic signed [TIME_W-1:0] entry_time;
    logic signed [TIME_W-1:0] query_time;
  } in_item_t;

  // Result item: bracket of a query
  typedef struct packed {
    logic [ROW_CNT_W-1:0]     bracket_row;
    logic signed [TIME_W-1:0] start_time;
    logic signed [TIME_W-1:0] end_time;
    logic                     outside_table;
  } out_item_t;

  // Search engine status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

@@ rtl/core/stbs_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_engine
// Timestamp memory, cached interval and the bisection sequencer. One
// memory read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module stbs_engine #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  req_valid,
  input  stbs_pkg::in_item_t                    req_item,
  input  logic [$clog2(TABLE_DEPTH + 1)-1:0]    rows_n,
  input  logic                                  cfg_wr,
  input  logic                                  take,
  output stbs_pkg::eng_stat_t                   stat,
  output stbs_pkg::out_item_t                   res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int RW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_LAST  = 3'd2;
  localparam logic [2:0] ST_BIS   = 3'd3;
  localparam logic [2:0] ST_EXACT = 3'd4;
  localparam logic [2:0] ST_EDGE  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  // Table memory
  logic [63:0]    mem [TABLE_DEPTH];
  logic [63:0]    rd_data_r;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic           idx_ok;

  logic [2:0]     state_r, state_nxt;
  logic [63:0]    q_r, q_nxt;
  logic [RW-1:0]  n_r, n_nxt;
  logic [63:0]    first_r, first_nxt;
  logic [RW-1:0]  r0_r, r0_nxt;
  logic [RW-1:0]  r1_r, r1_nxt;
  logic [RW-1:0]  mid_r, mid_nxt;
  logic [63:0]    t0_r, t0_nxt;
  logic [63:0]    t1_r, t1_nxt;
  logic           out_r, out_nxt;
  logic           edge_end_r, edge_end_nxt;

  logic [RW-1:0]  cache_row_r;
  logic [63:0]    cache_s_r;
  logic [63:0]    cache_e_r;
  logic           cache_vld_r;

  // Decision terms
  logic           lt_first, gt_last, eq_last, one_row, cache_hit;
  logic           hit_eq, q_below;
  logic [RW-1:0]  b_r0, b_r1;
  logic [RW:0]    mid_sum;
  logic [RW-1:0]  mid_new;

  assign idx_ok = 32'(req_item.entry_index) < 32'(TABLE_DEPTH);
  assign wr_en  = req_valid && (req_item.kind == stbs_pkg::KIND_LOAD) && idx_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(req_item.entry_index)] <= req_item.entry_time;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Compares against the probed entry
  assign lt_first  = $signed(q_r) < $signed(first_r);
  assign gt_last   = $signed(rd_data_r) < $signed(q_r);
  assign eq_last   = q_r == rd_data_r;
  assign one_row   = n_r == RW'(1);
  assign cache_hit = cache_vld_r && !($signed(q_r) < $signed(cache_s_r))
                     && ($signed(q_r) < $signed(cache_e_r));
  assign hit_eq    = rd_data_r == q_r;
  assign q_below   = $signed(q_r) < $signed(rd_data_r);

  // Next bisection bounds after a probe
  always_comb begin
    b_r0 = r0_r;
    b_r1 = r1_r;
    if (state_r == ST_LAST) begin
      b_r0 = RW'(1);
      b_r1 = n_r;
    end else if (q_below) begin
      b_r1 = mid_r;
    end else begin
      b_r0 = mid_r;
    end
    mid_sum = {1'b0, b_r0} + {1'b0, b_r1};
    mid_new = mid_sum[RW:1];
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    q_nxt        = q_r;
    n_nxt        = n_r;
    first_nxt    = first_r;
    r0_nxt       = r0_r;
    r1_nxt       = r1_r;
    mid_nxt      = mid_r;
    t0_nxt       = t0_r;
    t1_nxt       = t1_r;
    out_nxt      = out_r;
    edge_end_nxt = edge_end_r;
    rd_addr      = '0;
    case (state_r)
      ST_IDLE: begin
        if (req_valid && (req_item.kind == stbs_pkg::KIND_QUERY)) begin
          q_nxt     = req_item.query_time;
          n_nxt     = rows_n;
          rd_addr   = '0;
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        first_nxt = rd_data_r;
        rd_addr   = AW'(n_r - RW'(1));
        state_nxt = ST_LAST;
      end
      ST_LAST: begin
        if (lt_first || gt_last || eq_last) begin
          // query outside the table span
          out_nxt = 1'b1;
          if (one_row) begin
            r0_nxt    = RW'(1);
            t0_nxt    = first_r;
            t1_nxt    = first_r;
            state_nxt = ST_FIN;
          end else if (lt_first) begin
            r0_nxt       = RW'(1);
            t0_nxt       = first_r;
            edge_end_nxt = 1'b1;
            rd_addr      = AW'(1);
            state_nxt    = ST_EDGE;
          end else begin
            r0_nxt       = n_r - RW'(1);
            t1_nxt       = rd_data_r;
            edge_end_nxt = 1'b0;
            rd_addr      = AW'(n_r - RW'(2));
            state_nxt    = ST_EDGE;
          end
        end else if (cache_hit) begin
          r0_nxt    = cache_row_r;
          t0_nxt    = cache_s_r;
          t1_nxt    = cache_e_r;
          out_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          out_nxt = 1'b0;
          r0_nxt  = b_r0;
          r1_nxt  = b_r1;
          t0_nxt  = first_r;
          t1_nxt  = rd_data_r;
          if (b_r1 - b_r0 > RW'(1)) begin
            mid_nxt   = mid_new;
            rd_addr   = AW'(mid_new - RW'(1));
            state_nxt = ST_BIS;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_BIS: begin
        if (hit_eq) begin
          // exact hit: fetch the following row
          r0_nxt    = mid_r;
          t0_nxt    = rd_data_r;
          rd_addr   = AW'(mid_r);
          state_nxt = ST_EXACT;
        end else begin
          r0_nxt = b_r0;
          r1_nxt = b_r1;
          if (q_below) begin
            t1_nxt = rd_data_r;
          end else begin
            t0_nxt = rd_data_r;
          end
          if (b_r1 - b_r0 > RW'(1)) begin
            mid_nxt = mid_new;
            rd_addr = AW'(mid_new - RW'(1));
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_EXACT: begin
        t1_nxt    = rd_data_r;
        state_nxt = ST_FIN;
      end
      ST_EDGE: begin
        if (edge_end_r) begin
          t1_nxt = rd_data_r;
        end else begin
          t0_nxt = rd_data_r;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cache_vld_r <= 1'b0;
      cache_row_r <= '0;
      cache_s_r   <= '0;
      cache_e_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr || wr_en) begin
        cache_vld_r <= 1'b0;
      end else if ((state_r == ST_FIN) && take) begin
        cache_vld_r <= 1'b1;
        cache_row_r <= r0_r;
        cache_s_r   <= t0_r;
        cache_e_r   <= t1_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    n_r        <= n_nxt;
    first_r    <= first_nxt;
    r0_r       <= r0_nxt;
    r1_r       <= r1_nxt;
    mid_r      <= mid_nxt;
    t0_r       <= t0_nxt;
    t1_r       <= t1_nxt;
    out_r      <= out_nxt;
    edge_end_r <= edge_end_nxt;
  end

  assign stat.idle         = state_r == ST_IDLE;
  assign stat.done         = state_r == ST_FIN;
  assign res.bracket_row   = stbs_pkg::ROW_CNT_W'(r0_r);
  assign res.start_time    = t0_r;
  assign res.end_time      = t1_r;
  assign res.outside_table = out_r;

endmodule

@@ rtl/core/sorted_time_table_bracket_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_time_table_bracket_search
// Bracket search over a table of increasing timestamps with a cached
// last interval.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : requests. kind load writes entry_time at entry_index and
//            gives no result. kind query returns one result.
//   out_*  : one result per query: 1-based bracket row, its start and end
//            times, and whether the query fell outside the table span.
//   cfg_*  : writes row_count (always ready); write only while idle.
// Query steps after the first and last rows are read, one memory read
// per cycle:
//   edge of table         : reads the row next to that edge (no read
//                           with a one-row table)
//   cached interval hit   : no further reads; bisection: probes halve the
//                           row range, plus the following row on an exact hit
// One query is in flight at a time; the next request is taken the cycle
// after the result moves into the output register. A stalled receiver
// holds the engine only once a second result is ready; the input side
// keeps taking requests while the output register waits.
// Reset: row_count is 1 and the cache is empty; table contents are
// undefined until loaded, and no clearing pass runs.
// ----------------------------------------------------------------------------
module sorted_time_table_bracket_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stbs_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stbs_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [10:0]          cfg_data
);

  localparam int RW = $clog2(TABLE_DEPTH + 1);

  logic                      row_count_r;
  logic [10:0]               row_cnt_r;
  logic [RW-1:0]             rows_n;
  logic                      in_acc;
  logic                      cfg_acc;
  logic                      take;
  stbs_pkg::eng_stat_t       stat;
  stbs_pkg::out_item_t       res;
  logic                      out_valid_r, out_valid_nxt;
  stbs_pkg::out_item_t       out_item_r;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_ready  = stat.idle;
  assign in_acc    = in_valid && in_ready;

  // Row count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= 11'd1;
      row_count_r <= 1'b0;
    end else if (cfg_acc) begin
      row_cnt_r   <= cfg_data;
      row_count_r <= 1'b1;
    end
  end

  // Rows in use: zero acts as one, saturate at the table depth
  always_comb begin
    if (row_cnt_r == 11'd0) begin
      rows_n = RW'(1);
    end else if (32'(row_cnt_r) > 32'(TABLE_DEPTH)) begin
      rows_n = RW'(TABLE_DEPTH);
    end else begin
      rows_n = RW'(row_cnt_r);
    end
  end

  stbs_engine #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_acc),
    .req_item  (in_item),
    .rows_n    (rows_n),
    .cfg_wr    (cfg_acc),
    .take      (take),
    .stat      (stat),
    .res       (res)
  );

  // Output register
  assign take = stat.done && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  a_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.bracket_row != 11'd0))
    else $error("result row is zero");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_item.kind == stbs_pkg::KIND_QUERY)) |=> !in_ready)
    else $error("engine free right after a query request");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_item.kind == stbs_pkg::KIND_LOAD)) |=> in_ready)
    else $error("load request held the engine");

  a_cfg_seen: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (row_count_r && (row_cnt_r == $past(cfg_data))))
    else $error("row count write lost");

endmodule
